// ----- hdl/rtc_pkg.sv -----
// rtc_pkg: shared types, constants and helper functions of the RST temperature controller
// number formats, MAC program and coefficient table
// no dependencies
package rtc_pkg;

    // field and signal widths
    localparam int TEMP_W     = 16;
    localparam int STATE_W    = 48;
    localparam int DUTY_W     = 16;
    localparam int TEMP_SHIFT = 12;   // Q.4 temperature to 16 fraction bits
    localparam int LIM_SHIFT  = 16;   // duty counts to 16 fraction bits
    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = 24;
    localparam int HALF_W     = STATE_W / 2;
    localparam int HIGH_W     = STATE_W - HALF_W;
    localparam int MUL_A_W    = HIGH_W + 1;
    localparam int PROD_W     = MUL_A_W + COEF_W;
    localparam int ACC_W      = STATE_W + COEF_W + 4;
    localparam int FIN_W      = ACC_W - COEF_FRAC;

    // configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT     = CFG_IDX_W'(1);
    localparam logic signed [TEMP_W-1:0] REFERENCE_RESET = TEMP_W'(800);
    localparam logic [DUTY_W-1:0]        LIMIT_RESET     = DUTY_W'(1000);

    // microprogram length
    localparam int PROG_LEN = 29;
    localparam int PC_W     = $clog2(PROG_LEN);

    localparam logic signed [STATE_W-1:0] SMAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] SMIN = {1'b1, {(STATE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MLO,   // low half of signal times coefficient
        OP_MHI,   // high half of signal times coefficient, weighted by 2^HALF_W
        OP_ADD,   // signal times one
        OP_SUB,   // signal times minus one
        OP_FIN    // round down, saturate, write destination, clear accumulator
    } op_t;

    typedef enum logic [3:0] {
        SEL_REF, SEL_MEAS, SEL_PREF, SEL_MOD1, SEL_MOD2, SEL_MEAS1, SEL_MEAS2,
        SEL_SF1, SEL_INT, SEL_MODEL, SEL_REFT, SEL_MEASR, SEL_EPS, SEL_EPSS, SEL_RAW
    } sel_t;

    typedef enum logic [3:0] {
        K_NAM1, K_NAM2, K_BM0, K_BM1, K_T0, K_R0, K_R1, K_R2, K_NAS1
    } coef_t;

    typedef struct packed {
        op_t   op;
        sel_t  sel;
        coef_t coef;
    } step_t;

    // sequencer to datapath control
    typedef struct packed {
        logic  issue;   // step is valid this cycle
        step_t step;
        logic  load;    // latch reference and measurement of a new request
        logic  wb;      // commit state and push the result
        logic  clr;     // writeback clears all state
    } ctrl_t;

    // Q8.24 coefficients, feedback terms already negated
    function automatic logic signed [COEF_W-1:0] coef_value(input coef_t k);
        logic signed [COEF_W-1:0] v;
        unique case (k)
            K_NAM1:  v = COEF_W'(30258975);
            K_NAM2:  v = -COEF_W'(13721444);
            K_BM0:   v = COEF_W'(123858);
            K_BM1:   v = COEF_W'(115827);
            K_T0:    v = -COEF_W'(39832165);
            K_R0:    v = -COEF_W'(323105338);
            K_R1:    v = -COEF_W'(19916082);
            K_R2:    v = COEF_W'(303189256);
            K_NAS1:  v = COEF_W'(10876095);
            default: v = '0;
        endcase
        return v;
    endfunction

    // MAC program for one sample
    function automatic step_t prog_step(input logic [PC_W-1:0] pc);
        step_t s;
        unique case (int'(pc))
            // second-order setpoint prefilter
            0:  s = '{OP_MLO, SEL_MOD1,  K_NAM1};
            1:  s = '{OP_MHI, SEL_MOD1,  K_NAM1};
            2:  s = '{OP_MLO, SEL_MOD2,  K_NAM2};
            3:  s = '{OP_MHI, SEL_MOD2,  K_NAM2};
            4:  s = '{OP_MLO, SEL_REF,   K_BM0};
            5:  s = '{OP_MHI, SEL_REF,   K_BM0};
            6:  s = '{OP_MLO, SEL_PREF,  K_BM1};
            7:  s = '{OP_MHI, SEL_PREF,  K_BM1};
            8:  s = '{OP_FIN, SEL_MODEL, K_NAM1};
            // gain T
            9:  s = '{OP_MLO, SEL_MODEL, K_T0};
            10: s = '{OP_MHI, SEL_MODEL, K_T0};
            11: s = '{OP_FIN, SEL_REFT,  K_NAM1};
            // filter R on the measurement
            12: s = '{OP_MLO, SEL_MEAS,  K_R0};
            13: s = '{OP_MHI, SEL_MEAS,  K_R0};
            14: s = '{OP_MLO, SEL_MEAS1, K_R1};
            15: s = '{OP_MHI, SEL_MEAS1, K_R1};
            16: s = '{OP_MLO, SEL_MEAS2, K_R2};
            17: s = '{OP_MHI, SEL_MEAS2, K_R2};
            18: s = '{OP_FIN, SEL_MEASR, K_NAM1};
            // error
            19: s = '{OP_ADD, SEL_REFT,  K_NAM1};
            20: s = '{OP_SUB, SEL_MEASR, K_NAM1};
            21: s = '{OP_FIN, SEL_EPS,   K_NAM1};
            // filter S
            22: s = '{OP_MLO, SEL_SF1,   K_NAS1};
            23: s = '{OP_MHI, SEL_SF1,   K_NAS1};
            24: s = '{OP_ADD, SEL_EPS,   K_NAM1};
            25: s = '{OP_FIN, SEL_EPSS,  K_NAM1};
            // integrator
            26: s = '{OP_ADD, SEL_EPSS,  K_NAM1};
            27: s = '{OP_ADD, SEL_INT,   K_NAM1};
            28: s = '{OP_FIN, SEL_RAW,   K_NAM1};
            default: s = '{OP_NOP, SEL_REF, K_NAM1};
        endcase
        return s;
    endfunction

    // temperature to internal signal, saturated to the state range
    function automatic logic signed [STATE_W-1:0] temp_to_sig(
        input logic signed [TEMP_W-1:0] t
    );
        localparam int EXT_W = TEMP_W + TEMP_SHIFT + STATE_W;
        logic signed [EXT_W-1:0] p;
        logic signed [STATE_W-1:0] r;
        p = EXT_W'(t) <<< TEMP_SHIFT;
        if (p > EXT_W'(SMAX)) begin
            r = SMAX;
        end else if (p < EXT_W'(SMIN)) begin
            r = SMIN;
        end else begin
            r = p[STATE_W-1:0];
        end
        return r;
    endfunction

    // accumulator after rounding down, saturated to the state range
    function automatic logic signed [STATE_W-1:0] sat_fin(input logic signed [FIN_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > FIN_W'(SMAX)) begin
            r = SMAX;
        end else if (v < FIN_W'(SMIN)) begin
            r = SMIN;
        end else begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/rtc_mac.sv -----
// rtc_mac: shared multiply-accumulate unit of the controller
// one partial product or one shifted add per cycle, finish with floor and saturation
// depends on rtc_pkg
module rtc_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rtc_pkg::ctrl_t                     ctrl,
    input  logic signed [rtc_pkg::STATE_W-1:0] operand,
    output logic signed [rtc_pkg::STATE_W-1:0] fin_value
);
    import rtc_pkg::*;

    op_t                      op;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [COEF_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   shifted;
    logic signed [ACC_W-1:0]   add_next;
    logic signed [ACC_W-1:0]   add_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   sum;

    assign op = ctrl.issue ? ctrl.step.op : OP_NOP;

    // multiplier operand: unsigned low half or signed high half
    always_comb begin
        if (op == OP_MHI) begin
            mul_a = $signed({operand[STATE_W-1], operand[STATE_W-1:HALF_W]});
        end else begin
            mul_a = $signed({{(MUL_A_W-HALF_W){1'b0}}, operand[HALF_W-1:0]});
        end
    end

    assign mul_b   = coef_value(ctrl.step.coef);
    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign shifted = ACC_W'(operand) <<< COEF_FRAC;

    // addend for the next cycle
    always_comb begin
        unique case (op)
            OP_MLO:  add_next = ACC_W'(prod);
            OP_MHI:  add_next = ACC_W'(prod) <<< HALF_W;
            OP_ADD:  add_next = shifted;
            OP_SUB:  add_next = -shifted;
            default: add_next = '0;
        endcase
    end

    // accumulate, finish drops the fraction and clears
    assign sum       = acc_reg + add_reg;
    assign fin_value = sat_fin(sum[ACC_W-1:COEF_FRAC]);
    assign acc_next  = (op == OP_FIN) ? '0 : sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            add_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            add_reg <= add_next;
        end
    end

endmodule

// ----- hdl/rtc_regs.sv -----
// rtc_regs: controller state and intermediate signals, operand select, output clamp
// takes finished values from the MAC unit and commits state at writeback
// depends on rtc_pkg
module rtc_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rtc_pkg::ctrl_t                     ctrl,
    input  logic signed [rtc_pkg::TEMP_W-1:0]  reference_temp,
    input  logic [rtc_pkg::DUTY_W-1:0]         duty_limit,
    input  logic signed [rtc_pkg::TEMP_W-1:0]  temp_sample,
    input  logic signed [rtc_pkg::STATE_W-1:0] fin_value,
    output logic signed [rtc_pkg::STATE_W-1:0] operand,
    output logic [rtc_pkg::DUTY_W-1:0]         duty,
    output logic                               saturated
);
    import rtc_pkg::*;

    // controller state
    logic signed [STATE_W-1:0] pref_reg, mod1_reg, mod2_reg;
    logic signed [STATE_W-1:0] meas1_reg, meas2_reg, sf1_reg, int_reg;
    // per-sample signals
    logic signed [STATE_W-1:0] ref_reg, meas_reg, model_reg, reft_reg;
    logic signed [STATE_W-1:0] measr_reg, eps_reg, epss_reg, raw_reg;

    logic [STATE_W:0]          lim_ext;
    logic signed [STATE_W-1:0] lim;
    logic signed [STATE_W-1:0] u;
    logic                      fin_wr;

    assign fin_wr = ctrl.issue && (ctrl.step.op == OP_FIN);

    // operand select
    always_comb begin
        unique case (ctrl.step.sel)
            SEL_REF:   operand = ref_reg;
            SEL_MEAS:  operand = meas_reg;
            SEL_PREF:  operand = pref_reg;
            SEL_MOD1:  operand = mod1_reg;
            SEL_MOD2:  operand = mod2_reg;
            SEL_MEAS1: operand = meas1_reg;
            SEL_MEAS2: operand = meas2_reg;
            SEL_SF1:   operand = sf1_reg;
            SEL_INT:   operand = int_reg;
            SEL_MODEL: operand = model_reg;
            SEL_REFT:  operand = reft_reg;
            SEL_MEASR: operand = measr_reg;
            SEL_EPS:   operand = eps_reg;
            SEL_EPSS:  operand = epss_reg;
            SEL_RAW:   operand = raw_reg;
            default:   operand = '0;
        endcase
    end

    // integrator clamp to plus or minus the limit
    always_comb begin
        lim_ext = (STATE_W+1)'({duty_limit, {LIM_SHIFT{1'b0}}});
        if (lim_ext > (STATE_W+1)'(SMAX)) begin
            lim = SMAX;
        end else begin
            lim = lim_ext[STATE_W-1:0];
        end
        saturated = 1'b0;
        u         = raw_reg;
        if (raw_reg > lim) begin
            u         = lim;
            saturated = 1'b1;
        end
        if (raw_reg < -lim) begin
            u         = -lim;
            saturated = 1'b1;
        end
        duty = u[STATE_W-1] ? '0 : u[LIM_SHIFT+DUTY_W-1:LIM_SHIFT];
    end

    // per-sample signals: latched inputs and finished MAC results
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            ref_reg  <= temp_to_sig(reference_temp);
            meas_reg <= temp_to_sig(temp_sample);
        end
        if (fin_wr) begin
            unique case (ctrl.step.sel)
                SEL_MODEL: model_reg <= fin_value;
                SEL_REFT:  reft_reg  <= fin_value;
                SEL_MEASR: measr_reg <= fin_value;
                SEL_EPS:   eps_reg   <= fin_value;
                SEL_EPSS:  epss_reg  <= fin_value;
                SEL_RAW:   raw_reg   <= fin_value;
                default: ;
            endcase
        end
    end

    // state commit or clear at writeback
    always_ff @(posedge aclk) begin
        if (!aresetn || (ctrl.wb && ctrl.clr)) begin
            pref_reg  <= '0;
            mod1_reg  <= '0;
            mod2_reg  <= '0;
            meas1_reg <= '0;
            meas2_reg <= '0;
            sf1_reg   <= '0;
            int_reg   <= '0;
        end else if (ctrl.wb) begin
            pref_reg  <= ref_reg;
            mod2_reg  <= mod1_reg;
            mod1_reg  <= model_reg;
            meas2_reg <= meas1_reg;
            meas1_reg <= meas_reg;
            sf1_reg   <= epss_reg;
            int_reg   <= u;
        end
    end

endmodule

// ----- hdl/rtc_seq.sv -----
// rtc_seq: sequencer that steps the shared MAC through the sample program
// holds the program counter and the clear flag of the current request
// depends on rtc_pkg
module rtc_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic           action,
    input  logic           out_free,
    output logic           ready,
    output rtc_pkg::ctrl_t ctrl
);
    import rtc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WB} state_t;

    state_t           state_reg;
    logic [PC_W-1:0]  pc_reg;
    logic             clr_reg;

    assign ready      = (state_reg == S_IDLE);
    assign ctrl.issue = (state_reg == S_RUN);
    assign ctrl.step  = prog_step(pc_reg);
    assign ctrl.load  = start && !action;
    assign ctrl.wb    = (state_reg == S_WB) && out_free;
    assign ctrl.clr   = clr_reg;

    // state, program counter, request kind
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            clr_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        clr_reg   <= action;
                        pc_reg    <= '0;
                        state_reg <= action ? S_WB : S_RUN;
                    end
                end
                S_RUN: begin
                    if (pc_reg == PC_W'(PROG_LEN-1)) begin
                        state_reg <= S_WB;
                    end else begin
                        pc_reg <= pc_reg + 1'b1;
                    end
                end
                S_WB: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/rst_temperature_controller_top.sv -----
// rst_temperature_controller_top: RST temperature controller with integrator
// configuration registers, stream handshakes, output register
// depends on rtc_pkg, rtc_seq, rtc_mac, rtc_regs
//
// Usage:
//   s_ channel: one request per sample; s_tuser[0] = action (1 clears all
//   controller state), s_tdata[15:0] = measured temperature, Q12.4.
//   m_ channel: one result per request; m_tdata[15:0] = PWM duty,
//   m_tuser[0] = integrator hit the duty limit.
//   cfg_ channel: register index 0 = reference temperature, 1 = duty limit;
//   other indexes are ignored. Write only while the block is idle.
//   Sequence: a sample request runs 29 steps of the shared
//   multiply-accumulate unit plus a writeback; the next request is
//   taken only once the sequencer is idle again after that writeback.
//   A clear request skips the steps and goes straight to writeback.
//   Reset: reference 800, duty limit 1000, all filter state zero.
//   Stall: the result waits in the output register; the next request is
//   accepted meanwhile, and its writeback waits until the register frees.
module rst_temperature_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] temp_sample
    input  logic [0:0]  s_tuser,   // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] duty
    output logic [0:0]  m_tuser,   // [0] saturated
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtc_pkg::CFG_DAT_W-1:0] cfg_data
);
    import rtc_pkg::*;

    logic signed [TEMP_W-1:0]  reference_temp_reg;
    logic [DUTY_W-1:0]         duty_limit_reg;
    logic                      start;
    logic                      out_free;
    logic                      seq_ready;
    ctrl_t                     ctrl;
    logic signed [STATE_W-1:0] operand;
    logic signed [STATE_W-1:0] fin_value;
    logic [DUTY_W-1:0]         duty;
    logic                      saturated;
    logic                      m_valid_reg;
    logic [DUTY_W-1:0]         m_duty_reg;
    logic                      m_sat_reg;

    assign s_tready  = seq_ready;
    assign start     = s_tvalid && seq_ready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reference_temp_reg <= REFERENCE_RESET;
            duty_limit_reg     <= LIMIT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_REFERENCE_TEMP) begin
                reference_temp_reg <= TEMP_W'(cfg_data);
            end else if (cfg_index == REG_DUTY_LIMIT) begin
                duty_limit_reg <= DUTY_W'(cfg_data);
            end
        end
    end

    rtc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .action   (s_tuser[0]),
        .out_free (out_free),
        .ready    (seq_ready),
        .ctrl     (ctrl)
    );

    rtc_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .operand   (operand),
        .fin_value (fin_value)
    );

    rtc_regs u_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .reference_temp (reference_temp_reg),
        .duty_limit     (duty_limit_reg),
        .temp_sample    (TEMP_W'(s_tdata)),
        .fin_value      (fin_value),
        .operand        (operand),
        .duty           (duty),
        .saturated      (saturated)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.wb) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wb) begin
            m_duty_reg <= ctrl.clr ? '0 : duty;
            m_sat_reg  <= ctrl.clr ? 1'b0 : saturated;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_duty_reg;
    assign m_tuser[0] = m_sat_reg;

endmodule

// ----- tb/rtc_tb_pkg.sv -----
// rtc_tb_pkg: request codes shared by the controller testbench and its checker
// no dependencies
package rtc_tb_pkg;

    // action field of a request
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

endpackage

// ----- tb/rtc_checker.sv -----
// rtc_checker: watches the request, result and register channels of the controller,
// predicts duty and saturation per request and compares them in order
// depends on rtc_pkg, rtc_tb_pkg
module rtc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] temp_sample
    input  logic [0:0]  s_tuser,   // [0] action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] duty
    input  logic [0:0]  m_tuser,   // [0] saturated
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [rtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtc_pkg::CFG_DAT_W-1:0] cfg_data,
    output int          mismatch_count,
    output int          pending_results
);
    import rtc_pkg::*;
    import rtc_tb_pkg::*;

    // q8.24 coefficients, feedback terms negated
    localparam logic signed [31:0] KQ_BM0  = 32'sd123858;
    localparam logic signed [31:0] KQ_BM1  = 32'sd115827;
    localparam logic signed [31:0] KQ_AM1  = 32'sd30258975;
    localparam logic signed [31:0] KQ_AM2  = -32'sd13721444;
    localparam logic signed [31:0] KQ_T0   = -32'sd39832165;
    localparam logic signed [31:0] KQ_R0   = -32'sd323105338;
    localparam logic signed [31:0] KQ_R1   = -32'sd19916082;
    localparam logic signed [31:0] KQ_R2   = 32'sd303189256;
    localparam logic signed [31:0] KQ_ONE  = 32'sd16777216;
    localparam logic signed [31:0] KQ_S1   = 32'sd10876095;

    typedef struct packed {
        logic [15:0] duty;
        logic        saturated;
    } duty_res_t;

    // controller registers and filter state
    logic signed [15:0] setpoint;
    logic [15:0]        duty_bound;
    logic signed [47:0] ref_prev, model_z1, model_z2, meas_z1, meas_z2, sfilt_z1, integ;

    duty_res_t duty_expected[$];

    // exact product of a signal and a coefficient
    function automatic logic signed [95:0] mac_term(input logic signed [47:0] sig,
                                                    input logic signed [31:0] coef);
        logic signed [95:0] a;
        logic signed [95:0] b;
        a = sig;
        b = coef;
        return a * b;
    endfunction

    // floor divide by 2^24, then saturate to the 48-bit signal range
    function automatic logic signed [47:0] scale_q24(input logic signed [95:0] acc);
        logic signed [95:0] f;
        f = acc >>> 24;
        if (f > SMAX) begin
            return SMAX;
        end else if (f < SMIN) begin
            return SMIN;
        end
        return f[47:0];
    endfunction

    // one controller step: updates state, returns duty and saturation flag
    function automatic duty_res_t control_step(input logic act, input logic [15:0] temp);
        duty_res_t          r;
        logic signed [47:0] ref_sig, meas, model, reft, measr, eps, epss, raw, bound, u;
        logic signed [15:0] t_s;
        r = '0;
        if (act == ACT_CLEAR) begin
            ref_prev = '0; model_z1 = '0; model_z2 = '0;
            meas_z1  = '0; meas_z2  = '0; sfilt_z1 = '0; integ = '0;
            return r;
        end
        t_s     = temp;
        ref_sig = setpoint;
        ref_sig = ref_sig <<< 12;
        meas    = t_s;
        meas    = meas <<< 12;

        model = scale_q24(mac_term(model_z1, KQ_AM1) + mac_term(model_z2, KQ_AM2)
                        + mac_term(ref_sig, KQ_BM0) + mac_term(ref_prev, KQ_BM1));
        reft  = scale_q24(mac_term(model, KQ_T0));
        measr = scale_q24(mac_term(meas, KQ_R0) + mac_term(meas_z1, KQ_R1)
                        + mac_term(meas_z2, KQ_R2));
        eps   = scale_q24(mac_term(reft, KQ_ONE) + mac_term(measr, -KQ_ONE));
        epss  = scale_q24(mac_term(sfilt_z1, KQ_S1) + mac_term(eps, KQ_ONE));

        ref_prev = ref_sig;
        model_z2 = model_z1;
        model_z1 = model;
        meas_z2  = meas_z1;
        meas_z1  = meas;
        sfilt_z1 = epss;

        // integrator with anti-windup clamp
        raw   = scale_q24(mac_term(epss, KQ_ONE) + mac_term(integ, KQ_ONE));
        bound = {16'd0, duty_bound, 16'd0};
        u     = raw;
        if (u > bound) begin
            u = bound;
            r.saturated = 1'b1;
        end
        if (u < -bound) begin
            u = -bound;
            r.saturated = 1'b1;
        end
        integ  = u;
        r.duty = (u < 0) ? 16'd0 : u[31:16];
        return r;
    endfunction

    // sample all channels at the rising edge
    always @(posedge aclk) begin
        duty_res_t want;
        if (!aresetn) begin
            setpoint   = REFERENCE_RESET;
            duty_bound = LIMIT_RESET;
            ref_prev = '0; model_z1 = '0; model_z2 = '0;
            meas_z1  = '0; meas_z2  = '0; sfilt_z1 = '0; integ = '0;
            duty_expected.delete();
            mismatch_count = 0;
        end else begin
            // register writes, unknown indexes ignored
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_REFERENCE_TEMP: setpoint   = cfg_data;
                    REG_DUTY_LIMIT:     duty_bound = cfg_data;
                    default: ;
                endcase
            end
            // accepted request
            if (s_tvalid && s_tready) begin
                duty_expected.push_back(control_step(s_tuser[0], s_tdata));
            end
            // accepted result against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (duty_expected.size() == 0) begin
                    $error("unexpected result: duty %0d saturated %0d", m_tdata, m_tuser[0]);
                    mismatch_count++;
                end else begin
                    want = duty_expected.pop_front();
                    if (m_tdata !== want.duty) begin
                        $error("duty mismatch: expected %0d, actual %0d", want.duty, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tuser[0] !== want.saturated) begin
                        $error("saturated mismatch: expected %0d, actual %0d",
                               want.saturated, m_tuser[0]);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_results = duty_expected.size();
    end

endmodule

// ----- tb/rst_temperature_controller_top_tb.sv -----
// rst_temperature_controller_top_tb: stimulus and verdict for the RST temperature controller
// directed extremes, then random phases of setpoint and limit with bursty requests
// depends on rtc_pkg, rtc_tb_pkg, rtc_checker, rst_temperature_controller_top
module rst_temperature_controller_top_tb;
    import rtc_pkg::*;
    import rtc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int ITEM_TARGET = 1350;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;

    // register indexes outside the map
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int pending_results;
    int n_items     = 0;
    int burst_left  = 8;
    int hold_reqs   = 0;
    int hold_done   = 0;

    always #6 aclk = ~aclk;

    rst_temperature_controller_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rtc_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // offer one request, then keep the burst going or idle for a while
    task automatic offer(input logic act, input logic [15:0] temp);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= temp;
        do @(posedge aclk); while (!s_tready);
        n_items++;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
    endtask

    // stop sending until every outstanding result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);
    endtask

    // register write while the controller is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side: changing stall patterns, plus long hold-offs on request
    initial begin : rx_pattern
        int mode;
        int span;
        int k;
        int held;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(32, 256);
            for (k = 0; k < span; k++) begin
                @(negedge aclk);
                if (hold_done != hold_reqs) begin
                    m_tready <= 1'b0;
                    held = 1;
                    while (held < HOLD_CYCLES) begin
                        @(negedge aclk);
                        held++;
                    end
                    hold_done++;
                end else begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= ($urandom_range(0, 3) != 0);
                        2: m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= (k % 5 == 0);
                    endcase
                end
            end
        end
    end

    // cycle watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] ref_val;
        logic [15:0] lim_val;
        logic [15:0] t;
        int          ref_int;
        int          lvl;
        int          pick;
        int          phase_len;
        int          k;
        int          phase;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // unmapped register indexes must not disturb anything
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'h5A5A);

        // reset settings, temperature extremes and a clear
        offer(ACT_SAMPLE, 16'd800);
        offer(ACT_SAMPLE, 16'd0);
        offer(ACT_SAMPLE, 16'h7FFF);
        offer(ACT_SAMPLE, 16'h8000);
        offer(ACT_SAMPLE, 16'hFFFF);
        offer(ACT_SAMPLE, 16'd1);
        offer(ACT_CLEAR,  16'h7FFF);
        offer(ACT_SAMPLE, 16'd790);
        offer(ACT_SAMPLE, 16'd810);

        // zero limit: nonzero sums saturate, a zero sum does not
        write_reg(REG_DUTY_LIMIT, 16'd0);
        offer(ACT_SAMPLE, 16'd0);
        offer(ACT_SAMPLE, 16'hFFFF);
        write_reg(REG_REFERENCE_TEMP, 16'd0);
        offer(ACT_CLEAR,  16'd0);
        offer(ACT_SAMPLE, 16'd0);
        offer(ACT_SAMPLE, 16'd5);

        // widest limit with extreme setpoints
        write_reg(REG_DUTY_LIMIT, 16'hFFFF);
        write_reg(REG_REFERENCE_TEMP, 16'h7FFF);
        offer(ACT_CLEAR,  16'd0);
        offer(ACT_SAMPLE, 16'h8000);
        offer(ACT_SAMPLE, 16'h8000);
        write_reg(REG_REFERENCE_TEMP, 16'h8000);
        offer(ACT_SAMPLE, 16'h7FFF);
        offer(ACT_SAMPLE, 16'h7FFF);
        write_reg(REG_DUTY_LIMIT, 16'd1);
        offer(ACT_SAMPLE, 16'h8000);
        offer(ACT_SAMPLE, 16'd0);

        // random phases, each with its own setpoint and limit
        phase = 0;
        while (n_items < ITEM_TARGET) begin
            case ($urandom_range(0, 7))
                0:       ref_val = 16'h8000;
                1:       ref_val = 16'h7FFF;
                2, 3:    ref_val = 16'($urandom);
                default: ref_val = 16'($urandom_range(0, 4000)) - 16'd2000;
            endcase
            case ($urandom_range(0, 7))
                0:       lim_val = 16'd0;
                1:       lim_val = 16'hFFFF;
                2:       lim_val = 16'd1;
                3, 4:    lim_val = 16'($urandom);
                default: lim_val = 16'($urandom_range(200, 5000));
            endcase
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_REFERENCE_TEMP, ref_val);
                write_reg(REG_DUTY_LIMIT, lim_val);
            end else begin
                write_reg(REG_DUTY_LIMIT, lim_val);
                write_reg(REG_REFERENCE_TEMP, ref_val);
            end
            if ($urandom_range(0, 1) == 0) begin
                offer(ACT_CLEAR, 16'($urandom));
            end
            ref_int = $signed(ref_val);
            lvl     = ref_int;

            // result side holds off while requests keep coming
            if (phase == 2 || phase == 6) begin
                hold_reqs++;
            end

            phase_len = $urandom_range(60, 160);
            for (k = 0; k < phase_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    offer(ACT_CLEAR, 16'($urandom));
                end else begin
                    if (pick < 64) begin
                        // slow drift around the setpoint
                        lvl = lvl + int'($urandom_range(0, 16)) - 8;
                        if (lvl > 32767) begin
                            lvl = 32767;
                        end else if (lvl < -32768) begin
                            lvl = -32768;
                        end
                        t = 16'(lvl);
                    end else if (pick < 86) begin
                        t = 16'($urandom);
                    end else if (pick < 94) begin
                        t = 16'(ref_int + int'($urandom_range(0, 128)) - 64);
                    end else begin
                        case ($urandom_range(0, 3))
                            0:       t = 16'h8000;
                            1:       t = 16'h7FFF;
                            2:       t = 16'h0000;
                            default: t = 16'hFFFF;
                        endcase
                    end
                    offer(ACT_SAMPLE, t);
                end
                if ($urandom_range(0, 99) == 0) begin
                    drain();
                end
            end
            phase++;
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
